@@ sv/msm_pkg.sv @@
// Package for the multi-pattern string matcher.
// Operation and status codes, and the command item passed from front to back.
// No dependencies.
`default_nettype none

package msm_pkg;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_END     = 2'd1,
    OP_COMPILE = 2'd2,
    OP_MATCH   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NODE_FULL    = 2'd1,
    ST_ID_FULL      = 2'd2,
    ST_NOT_COMPILED = 2'd3
  } status_t;

  localparam int SYM_W = 5;
  localparam int ID_W  = 16;

  typedef struct packed {
    op_t              op;
    logic             sym_ok;
    logic             first;
    logic [SYM_W-1:0] symbol;
    logic [ID_W-1:0]  pattern_id;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/msm_if.sv @@
// Handshake channels of the matcher: input items and result items.
// Depends on nothing.
`default_nettype none

interface msm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [4:0]  symbol;
  logic        first;
  logic [15:0] pattern_id;
  modport source(output valid, mode, symbol, first, pattern_id, input ready);
  modport sink(input valid, mode, symbol, first, pattern_id, output ready);
endinterface

interface msm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [15:0] match_id;
  logic        last;
  modport source(output valid, status, found, match_id, last, input ready);
  modport sink(input valid, status, found, match_id, last, output ready);
endinterface

`default_nettype wire

@@ sv/msm_front.sv @@
// Front of the matcher: accepts input items, decodes them, two-entry queue.
// Depends on msm_pkg and msm_in_if.
`default_nettype none

module msm_front #(
  parameter int ALPHABET = 26
) (
  input  wire logic          clk,
  input  wire logic          rst,
  msm_in_if.sink             item_in,
  output msm_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);
  import msm_pkg::*;

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  cmd_t       dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec.op         = op_t'(item_in.mode);
    dec.sym_ok     = 32'(item_in.symbol) < 32'(ALPHABET);
    dec.first      = item_in.first;
    dec.symbol     = item_in.symbol;
    dec.pattern_id = item_in.pattern_id;
  end

  assign item_in.ready = cnt != 2'd2;
  assign cmd_valid     = cnt != 2'd0;
  assign cmd           = q[rp];
  assign push          = item_in.valid && item_in.ready;
  assign pop           = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 || cnt == 2'd2) |-> wp == rp)
    else $error("queue pointers inconsistent");
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 && !item_in.valid) |=> cnt == 2'd0)
    else $error("queue filled without push");
`endif

endmodule

`default_nettype wire

@@ sv/msm_engine.sv @@
// Back of the matcher: trie, failure links, id lists, sequencer, result register.
// Depends on msm_pkg and msm_out_if.
`default_nettype none

module msm_engine #(
  parameter int NODES    = 256,
  parameter int ALPHABET = 26,
  parameter int MAX_IDS  = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire msm_pkg::cmd_t cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  msm_out_if.source          res
);
  import msm_pkg::*;

  localparam int NW   = $clog2(NODES);
  localparam int NCW  = NW + 1;
  localparam int SYW  = $clog2(ALPHABET);
  localparam int XW   = (SYW > SYM_W) ? SYW : SYM_W;
  localparam int CD   = NODES * ALPHABET;
  localparam int CAW  = $clog2(CD);
  localparam int IW   = $clog2(MAX_IDS + 1);
  localparam int IXW  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam logic [IW-1:0]  NIL    = IW'(MAX_IDS);
  localparam logic [NW-1:0]  ROOT   = '0;
  localparam logic [SYW-1:0] SYMLST = SYW'(ALPHABET - 1);

  typedef enum logic [4:0] {
    INIT, SW, IDLE, EMIT,
    I_RD, I_CHK,
    E_RD, E_LINK,
    CP_INIT, CR_RD, CR_USE, CQ_POP, CQ_U, CQ_F, CK_RD, CK_USE, CW_RD, CW_USE, CW_F,
    M_RD, M_USE, M_F,
    R_NODE, R_HEAD, R_E, R_ID, R_FT, R_END
  } state_t;

  state_t         state;
  logic [NCW-1:0] node_count;
  logic [IW-1:0]  id_count;
  logic [NW-1:0]  build_node;
  logic [NW-1:0]  match_node;
  logic           compiled;
  logic [NW-1:0]  u, f, fu, cn, t, newn;
  logic [IW-1:0]  e, n;
  logic [SYW-1:0] ci, sym;
  logic [NCW-1:0] qh, qt, guard;
  logic           pend_valid, sw_emit;
  logic [ID_W-1:0] pend_id, pid;
  status_t        res_status;

  logic           ov;
  status_t        o_status;
  logic           o_found, o_last;
  logic [ID_W-1:0] o_id;

  // Memories
  logic [NW-1:0]   child_mem [CD];
  logic [NW-1:0]   fail_mem  [NODES];
  logic [NW-1:0]   queue_mem [NODES];
  logic [IW-1:0]   head_mem  [NODES];
  logic [IW-1:0]   tail_mem  [NODES];
  logic [ID_W-1:0] idv_mem   [MAX_IDS];
  logic [IW-1:0]   inx_mem   [MAX_IDS];

  logic [NW-1:0]   child_rd, fail_rd, queue_rd;
  logic [IW-1:0]   head_rd, tail_rd, inx_rd;
  logic [ID_W-1:0] idv_rd;

  logic [NW-1:0]  cr_node, cw_node, fail_ra, fail_wa, fail_wd, queue_wd, ht_a, ht_wa;
  logic [SYW-1:0] cr_sym, cw_sym;
  logic [CAW-1:0] child_ra, child_wa;
  logic           child_we, fail_we, queue_we, head_we, tail_we, idv_we, inx_we;
  logic [NW-1:0]  child_wd;
  logic [IW-1:0]  head_wd, tail_wd, inx_wd;
  logic [IXW-1:0] inx_wa;
  logic [NW-1:0]  new_idx, b_node, m_node;
  logic [SYW-1:0] cmd_sym;
  logic [XW-1:0]  sx;
  logic           ob_free, node_full, q_room, cw_hit;

  assign sx        = XW'(cmd.symbol);
  assign cmd_sym   = sx[SYW-1:0];
  assign new_idx   = node_count[NW-1:0];
  assign node_full = node_count == NCW'(NODES);
  assign q_room    = qt < NCW'(NODES);
  assign cw_hit    = (child_rd != ROOT) || (f == ROOT);
  assign ob_free   = !ov || res.ready;
  assign b_node    = cmd.first ? ROOT : build_node;
  assign m_node    = cmd.first ? ROOT : match_node;
  assign cmd_ready = state == IDLE;

  // Read addresses
  always_comb begin
    unique case (state)
      CR_RD:   begin cr_node = ROOT;       cr_sym = ci;  end
      CK_RD:   begin cr_node = u;          cr_sym = ci;  end
      CW_RD:   begin cr_node = f;          cr_sym = ci;  end
      I_RD:    begin cr_node = build_node; cr_sym = sym; end
      M_RD:    begin cr_node = u;          cr_sym = sym; end
      default: begin cr_node = ROOT;       cr_sym = '0;  end
    endcase
    unique case (state)
      CQ_U:    fail_ra = queue_rd;
      CW_USE:  fail_ra = f;
      M_USE:   fail_ra = u;
      default: fail_ra = t;
    endcase
    ht_a = (state == E_RD) ? build_node : t;
  end

  assign child_ra = CAW'(cr_node) * CAW'(ALPHABET) + CAW'(cr_sym);
  assign child_wa = CAW'(cw_node) * CAW'(ALPHABET) + CAW'(cw_sym);

  // Write controls
  always_comb begin
    child_we = 1'b0; cw_node = build_node; cw_sym = sym; child_wd = '0;
    fail_we  = 1'b0; fail_wa = ROOT; fail_wd = ROOT;
    queue_we = 1'b0; queue_wd = child_rd;
    head_we  = 1'b0; tail_we = 1'b0; ht_wa = build_node;
    head_wd  = NIL;  tail_wd = NIL;
    idv_we   = 1'b0; inx_we = 1'b0;
    inx_wa   = id_count[IXW-1:0]; inx_wd = NIL;
    unique case (state)
      INIT: begin
        head_we = 1'b1; tail_we = 1'b1; ht_wa = ROOT;
      end
      SW: begin
        child_we = 1'b1; cw_node = newn; cw_sym = ci;
      end
      I_CHK: begin
        if (child_rd == ROOT && !node_full) begin
          child_we = 1'b1; child_wd = new_idx;
          head_we = 1'b1; tail_we = 1'b1; ht_wa = new_idx;
        end
      end
      E_RD: begin
        idv_we = 1'b1; inx_we = 1'b1;
      end
      E_LINK: begin
        tail_we = 1'b1; tail_wd = id_count;
        if (head_rd == NIL) begin
          head_we = 1'b1; head_wd = id_count;
        end else begin
          inx_we = 1'b1; inx_wa = tail_rd[IXW-1:0]; inx_wd = id_count;
        end
      end
      CP_INIT: begin
        fail_we = 1'b1;
      end
      CR_USE: begin
        if (child_rd != ROOT && q_room) begin
          fail_we = 1'b1; fail_wa = child_rd;
          queue_we = 1'b1;
        end
      end
      CW_USE: begin
        if (cw_hit) begin
          fail_we = 1'b1; fail_wa = cn; fail_wd = child_rd;
          queue_we = q_room; queue_wd = cn;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (child_we) child_mem[child_wa] <= child_wd;
    child_rd <= child_mem[child_ra];
  end

  always_ff @(posedge clk) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_rd <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[qt[NW-1:0]] <= queue_wd;
    queue_rd <= queue_mem[qh[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[ht_wa] <= head_wd;
    if (tail_we) tail_mem[ht_wa] <= tail_wd;
    head_rd <= head_mem[ht_a];
    tail_rd <= tail_mem[ht_a];
  end

  always_ff @(posedge clk) begin
    if (idv_we) idv_mem[id_count[IXW-1:0]] <= pid;
    if (inx_we) inx_mem[inx_wa] <= inx_wd;
    idv_rd <= idv_mem[e[IXW-1:0]];
    inx_rd <= inx_mem[e[IXW-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= INIT;
      node_count <= NCW'(1);
      id_count   <= '0;
      build_node <= ROOT;
      match_node <= ROOT;
      compiled   <= 1'b0;
      newn       <= ROOT;
      ci         <= '0;
      sw_emit    <= 1'b0;
      pend_valid <= 1'b0;
      ov         <= 1'b0;
    end else begin
      if (res.ready) ov <= 1'b0;
      unique case (state)
        INIT: begin
          newn <= ROOT; ci <= '0; sw_emit <= 1'b0;
          state <= SW;
        end
        SW: begin
          ci <= ci + 1'b1;
          if (ci == SYMLST) state <= sw_emit ? EMIT : IDLE;
        end
        IDLE: begin
          if (cmd_valid) begin
            sym <= cmd_sym;
            pid <= cmd.pattern_id;
            res_status <= ST_OK;
            unique case (cmd.op)
              OP_INSERT: begin
                compiled   <= 1'b0;
                build_node <= b_node;
                state      <= cmd.sym_ok ? I_RD : EMIT;
              end
              OP_END: begin
                build_node <= b_node;
                if (id_count == NIL) begin
                  res_status <= ST_ID_FULL;
                  state <= EMIT;
                end else begin
                  state <= E_RD;
                end
              end
              OP_COMPILE: state <= CP_INIT;
              OP_MATCH: begin
                n <= '0; guard <= '0; pend_valid <= 1'b0;
                if (!compiled) begin
                  res_status <= ST_NOT_COMPILED;
                  state <= EMIT;
                end else if (!cmd.sym_ok) begin
                  match_node <= ROOT; t <= ROOT;
                  state <= R_NODE;
                end else begin
                  u <= m_node;
                  state <= M_RD;
                end
              end
            endcase
          end
        end
        EMIT: begin
          if (ob_free) begin
            ov <= 1'b1; o_status <= res_status; o_found <= 1'b0;
            o_id <= '0; o_last <= 1'b1;
            state <= IDLE;
          end
        end
        I_RD: state <= I_CHK;
        I_CHK: begin
          if (child_rd != ROOT) begin
            build_node <= child_rd;
            state <= EMIT;
          end else if (node_full) begin
            res_status <= ST_NODE_FULL;
            state <= EMIT;
          end else begin
            newn <= new_idx; build_node <= new_idx;
            node_count <= node_count + 1'b1;
            ci <= '0; sw_emit <= 1'b1;
            state <= SW;
          end
        end
        E_RD: state <= E_LINK;
        E_LINK: begin
          id_count <= id_count + 1'b1;
          state <= EMIT;
        end
        CP_INIT: begin
          qh <= '0; qt <= '0; ci <= '0;
          state <= CR_RD;
        end
        CR_RD: state <= CR_USE;
        CR_USE: begin
          if (child_rd != ROOT && q_room) qt <= qt + 1'b1;
          ci <= ci + 1'b1;
          state <= (ci == SYMLST) ? CQ_POP : CR_RD;
        end
        CQ_POP: begin
          if (qh == qt) begin
            compiled <= 1'b1;
            state <= EMIT;
          end else begin
            qh <= qh + 1'b1;
            state <= CQ_U;
          end
        end
        CQ_U: begin
          u <= queue_rd;
          state <= CQ_F;
        end
        CQ_F: begin
          fu <= fail_rd; ci <= '0;
          state <= CK_RD;
        end
        CK_RD: state <= CK_USE;
        CK_USE: begin
          if (child_rd == ROOT) begin
            ci <= ci + 1'b1;
            state <= (ci == SYMLST) ? CQ_POP : CK_RD;
          end else begin
            cn <= child_rd; f <= fu;
            state <= CW_RD;
          end
        end
        CW_RD: state <= CW_USE;
        CW_USE: begin
          if (cw_hit) begin
            if (q_room) qt <= qt + 1'b1;
            ci <= ci + 1'b1;
            state <= (ci == SYMLST) ? CQ_POP : CK_RD;
          end else begin
            state <= CW_F;
          end
        end
        CW_F: begin
          f <= fail_rd;
          state <= CW_RD;
        end
        M_RD: state <= M_USE;
        M_USE: begin
          if (child_rd != ROOT || u == ROOT) begin
            match_node <= child_rd; t <= child_rd;
            state <= R_NODE;
          end else begin
            state <= M_F;
          end
        end
        M_F: begin
          u <= fail_rd;
          state <= M_RD;
        end
        R_NODE: begin
          state <= (t == ROOT || guard == NCW'(NODES)) ? R_END : R_HEAD;
        end
        R_HEAD: begin
          e <= head_rd;
          state <= R_E;
        end
        R_E: begin
          state <= (e == NIL || n == NIL) ? R_FT : R_ID;
        end
        R_ID: begin
          if (!pend_valid || ob_free) begin
            if (pend_valid) begin
              ov <= 1'b1; o_status <= ST_OK; o_found <= 1'b1;
              o_id <= pend_id; o_last <= 1'b0;
            end
            pend_id <= idv_rd; pend_valid <= 1'b1;
            n <= n + 1'b1; e <= inx_rd;
            state <= R_E;
          end
        end
        R_FT: begin
          t <= fail_rd; guard <= guard + 1'b1;
          state <= R_NODE;
        end
        R_END: begin
          if (ob_free) begin
            ov <= 1'b1; o_status <= ST_OK; o_found <= pend_valid;
            o_id <= pend_valid ? pend_id : '0; o_last <= 1'b1;
            pend_valid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign res.valid    = ov;
  assign res.status   = o_status;
  assign res.found    = o_found;
  assign res.match_id = o_id;
  assign res.last     = o_last;

`ifndef SYNTHESIS
  a_nodes: assert property (@(posedge clk) disable iff (rst)
    node_count != '0 && node_count <= NCW'(NODES))
    else $error("node count out of range");
  a_ids: assert property (@(posedge clk) disable iff (rst) id_count <= NIL)
    else $error("id count out of range");
  a_compile: assert property (@(posedge clk) disable iff (rst)
    $rose(compiled) |-> $past(state == CQ_POP))
    else $error("compiled set outside link pass");
  a_reported: assert property (@(posedge clk) disable iff (rst)
    (state == R_ID) |-> n < NIL)
    else $error("too many ids reported");
`endif

endmodule

`default_nettype wire

@@ sv/multi_pattern_string_matcher_unit.sv @@
// Top level of the multi-pattern string matcher (trie with failure links).
// Depends on msm_pkg, msm_if, msm_front and msm_engine.
//
//  channel     dir  payload                              accepted when
//  item_in     in   mode, symbol, first, pattern_id      valid && ready
//  result_out  out  status, found, match_id, last        valid && ready
//
// After reset the root row is cleared before items run.
// Insert clears the child row of each newly allocated node. End appends the pattern id to the node's id list.
// Compile visits nodes breadth first, setting each child's failure link by following failure hops.
// Match follows failure hops, then reports the ids of each node along the failure chain.
// The back end runs one item at a time, one read per table per cycle;
// a two-entry queue accepts up to two items while the back end or output stalls.
`default_nettype none

module multi_pattern_string_matcher_unit #(
  parameter int NODES    = 256,
  parameter int ALPHABET = 26,
  parameter int MAX_IDS  = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  msm_in_if.sink    item_in,
  msm_out_if.source result_out
);
  import msm_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  msm_front #(.ALPHABET(ALPHABET)) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_in),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  msm_engine #(.NODES(NODES), .ALPHABET(ALPHABET), .MAX_IDS(MAX_IDS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res       (result_out)
  );

endmodule

`default_nettype wire
